// ===== rtl/jac_pkg.sv =====
package jac_pkg;

  // Field widths
  localparam int SampleW = 12;
  localparam int LiftW   = 10;
  localparam int AxisW   = 8;
  localparam int BandW   = 7;
  localparam int CountW  = 8;

  // Configuration register indexes (word address paddr[4:2])
  localparam logic [2:0] REG_PITCH_CENTER  = 3'd0;
  localparam logic [2:0] REG_ROLL_CENTER   = 3'd1;
  localparam logic [2:0] REG_YAW_CENTER    = 3'd2;
  localparam logic [2:0] REG_DEAD_BAND     = 3'd3;
  localparam logic [2:0] REG_AXIS_LIMIT    = 3'd4;
  localparam logic [2:0] REG_YAW_GATE_LIFT = 3'd5;
  localparam logic [2:0] REG_ARM_HOLD      = 3'd6;
  localparam logic [2:0] REG_DISARM_HOLD   = 3'd7;

  // Register reset values
  localparam logic [SampleW-1:0] PITCH_CENTER_RST  = 12'd2032;
  localparam logic [SampleW-1:0] ROLL_CENTER_RST   = 12'd2019;
  localparam logic [SampleW-1:0] YAW_CENTER_RST    = 12'd2068;
  localparam logic [BandW-1:0]   DEAD_BAND_RST     = 7'd10;
  localparam logic [BandW-1:0]   AXIS_LIMIT_RST    = 7'd125;
  localparam logic [LiftW-1:0]   YAW_GATE_LIFT_RST = 10'd100;
  localparam logic [CountW-1:0]  ARM_HOLD_RST      = 8'd100;
  localparam logic [CountW-1:0]  DISARM_HOLD_RST   = 8'd15;

  // Gesture thresholds
  localparam logic [SampleW-1:0] GESTURE_LOW_LIFT = 12'd25;
  localparam logic [SampleW-1:0] ARM_X_ABOVE      = 12'd3600;
  localparam logic [SampleW-1:0] DISARM_X_BELOW   = 12'd450;
  localparam logic [CountW-1:0]  COUNT_AFTER_FIRE = 8'd160;

  // Divide by six: floor(y * 2731 / 2^14) is exact for all 12-bit y
  localparam logic [SampleW-1:0] LIFT_RECIP = 12'd2731;
  localparam int                 LiftShift  = 14;
  localparam logic [LiftW-1:0]   LIFT_MAX   = 10'd682;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_DISARM = 2'd1,
    EVT_ARM    = 2'd2
  } evt_t;

  typedef struct packed {
    logic [SampleW-1:0] left_x;
    logic [SampleW-1:0] left_y;
    logic [SampleW-1:0] right_x;
    logic [SampleW-1:0] right_y;
  } sample_t;

  typedef struct packed {
    logic [LiftW-1:0]        lift;
    logic signed [AxisW-1:0] pitch;
    logic signed [AxisW-1:0] roll;
    logic signed [AxisW-1:0] yaw;
    logic [1:0]              command;
    logic [1:0]              vibrate_event;
  } result_t;

  typedef struct packed {
    logic [BandW-1:0] dead_band;
    logic [BandW-1:0] axis_limit;
  } axis_cfg_t;

endpackage

// ===== rtl/jac_axis.sv =====
module jac_axis (
  input  logic [jac_pkg::SampleW-1:0]      sample,
  input  logic [jac_pkg::SampleW-1:0]      center,
  input  jac_pkg::axis_cfg_t               cfg,
  output logic signed [jac_pkg::AxisW-1:0] value
);
  import jac_pkg::*;

  logic signed [SampleW:0] diff;
  logic signed [SampleW:0] biased;
  logic signed [9:0]       scaled;
  logic signed [9:0]       band;
  logic signed [9:0]       limit;
  logic signed [9:0]       banded;
  logic signed [9:0]       clamped;

  // Offset from center, then divide by 16 rounding toward zero
  assign diff   = $signed({1'b0, sample}) - $signed({1'b0, center});
  assign biased = diff[SampleW] ? diff + 13'sd15 : diff;
  assign scaled = 10'(biased >>> 4);

  assign band  = $signed({3'b000, cfg.dead_band});
  assign limit = $signed({3'b000, cfg.axis_limit});

  // Remove dead band, then clamp symmetrically
  always_comb begin
    if (scaled >= band) begin
      banded = scaled - band;
    end else if (scaled <= -band) begin
      banded = scaled + band;
    end else begin
      banded = '0;
    end

    if (banded >= limit) begin
      clamped = limit;
    end else if (banded <= -limit) begin
      clamped = -limit;
    end else begin
      clamped = banded;
    end
  end

  assign value = clamped[AxisW-1:0];

endmodule

// ===== rtl/joystick_axis_conditioner_core.sv =====
// Joystick axis conditioner: each transfer on the sample channel carries one
// set of four 12-bit stick samples and yields exactly one result transfer with
// lift (left_y / 6), conditioned pitch, roll and yaw (centered, divided by 16,
// dead band removed, clamped; yaw is zero unless lift exceeds the yaw gate),
// the held arm/disarm command and a vibration event. The block accepts one
// sample set per clock while results drain. A sample set is captured in the
// input register and its result is loaded into the result register as soon as
// that register is free. A stalled result holds the result register; once the
// input register is also full the sample channel stalls until the result moves.
// Gesture hold counters advance once per sample set, so hold times are counted
// in sample sets. Configuration registers sit on the APB port at byte address
// 4*index; the user must write them only while no sample set is in flight, as
// the block itself does not enforce this.
module joystick_axis_conditioner_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  jac_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output jac_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import jac_pkg::*;

  // Configuration registers
  logic [SampleW-1:0] pitch_center;
  logic [SampleW-1:0] roll_center;
  logic [SampleW-1:0] yaw_center;
  logic [BandW-1:0]   dead_band;
  logic [BandW-1:0]   axis_limit;
  logic [LiftW-1:0]   yaw_gate_lift;
  logic [CountW-1:0]  arm_hold_ticks;
  logic [CountW-1:0]  disarm_hold_ticks;

  // Pipeline and gesture state
  logic              s1_valid;
  sample_t           s1;
  logic [CountW-1:0] arm_count;
  logic [CountW-1:0] disarm_count;
  cmd_t              held_command;

  logic              s1_advance;
  logic              cfg_write;
  logic [2:0]        reg_index;
  axis_cfg_t         axis_cfg;

  logic [2*SampleW-1:0]    lift_prod;
  logic [LiftW-1:0]        lift;
  logic signed [AxisW-1:0] pitch;
  logic signed [AxisW-1:0] roll;
  logic signed [AxisW-1:0] yaw_raw;
  logic signed [AxisW-1:0] yaw;

  logic              low_lift;
  logic              arm_gesture;
  logic              disarm_gesture;
  logic [CountW-1:0] arm_inc;
  logic [CountW-1:0] disarm_inc;
  logic              arm_fire;
  logic              disarm_fire;
  logic [CountW-1:0] arm_count_next;
  logic [CountW-1:0] disarm_count_next;
  cmd_t              held_command_next;
  evt_t              event_next;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_center      <= PITCH_CENTER_RST;
      roll_center       <= ROLL_CENTER_RST;
      yaw_center        <= YAW_CENTER_RST;
      dead_band         <= DEAD_BAND_RST;
      axis_limit        <= AXIS_LIMIT_RST;
      yaw_gate_lift     <= YAW_GATE_LIFT_RST;
      arm_hold_ticks    <= ARM_HOLD_RST;
      disarm_hold_ticks <= DISARM_HOLD_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_PITCH_CENTER:  pitch_center      <= pwdata[SampleW-1:0];
        REG_ROLL_CENTER:   roll_center       <= pwdata[SampleW-1:0];
        REG_YAW_CENTER:    yaw_center        <= pwdata[SampleW-1:0];
        REG_DEAD_BAND:     dead_band         <= pwdata[BandW-1:0];
        REG_AXIS_LIMIT:    axis_limit        <= pwdata[BandW-1:0];
        REG_YAW_GATE_LIFT: yaw_gate_lift     <= pwdata[LiftW-1:0];
        REG_ARM_HOLD:      arm_hold_ticks    <= pwdata[CountW-1:0];
        REG_DISARM_HOLD:   disarm_hold_ticks <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_index)
      REG_PITCH_CENTER:  prdata = 32'(pitch_center);
      REG_ROLL_CENTER:   prdata = 32'(roll_center);
      REG_YAW_CENTER:    prdata = 32'(yaw_center);
      REG_DEAD_BAND:     prdata = 32'(dead_band);
      REG_AXIS_LIMIT:    prdata = 32'(axis_limit);
      REG_YAW_GATE_LIFT: prdata = 32'(yaw_gate_lift);
      REG_ARM_HOLD:      prdata = 32'(arm_hold_ticks);
      REG_DISARM_HOLD:   prdata = 32'(disarm_hold_ticks);
      default:           prdata = '0;
    endcase
  end

  // Handshake: the input register drains whenever the result register is free
  assign s1_advance   = s1_valid && !(result_valid && result_stall);
  assign sample_stall = s1_valid && result_valid && result_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1 <= sample;
    end
  end

  // Lift: divide by six through a reciprocal multiply
  assign lift_prod = s1.left_y * LIFT_RECIP;
  assign lift      = lift_prod[LiftShift +: LiftW];

  // Axis conditioning
  assign axis_cfg.dead_band  = dead_band;
  assign axis_cfg.axis_limit = axis_limit;

  jac_axis u_pitch (
    .sample (s1.right_y),
    .center (pitch_center),
    .cfg    (axis_cfg),
    .value  (pitch)
  );

  jac_axis u_roll (
    .sample (s1.right_x),
    .center (roll_center),
    .cfg    (axis_cfg),
    .value  (roll)
  );

  jac_axis u_yaw (
    .sample (s1.left_x),
    .center (yaw_center),
    .cfg    (axis_cfg),
    .value  (yaw_raw)
  );

  // Gate yaw on lift
  assign yaw = (lift > yaw_gate_lift) ? yaw_raw : '0;

  // Gesture detection and hold counting
  assign low_lift       = s1.left_y < GESTURE_LOW_LIFT;
  assign arm_gesture    = low_lift && (s1.left_x > ARM_X_ABOVE);
  assign disarm_gesture = low_lift && (s1.left_x < DISARM_X_BELOW);
  assign arm_inc        = arm_count + 8'd1;
  assign disarm_inc     = disarm_count + 8'd1;
  assign arm_fire       = arm_gesture && (arm_inc > arm_hold_ticks);
  assign disarm_fire    = disarm_gesture && (disarm_inc > disarm_hold_ticks);

  always_comb begin
    if (!arm_gesture) begin
      arm_count_next = '0;
    end else if (arm_fire) begin
      arm_count_next = COUNT_AFTER_FIRE;
    end else begin
      arm_count_next = arm_inc;
    end

    if (!disarm_gesture) begin
      disarm_count_next = '0;
    end else if (disarm_fire) begin
      disarm_count_next = COUNT_AFTER_FIRE;
    end else begin
      disarm_count_next = disarm_inc;
    end

    if (disarm_fire) begin
      held_command_next = CMD_DISARM;
      event_next        = EVT_DISARM;
    end else if (arm_fire) begin
      held_command_next = CMD_ARM;
      event_next        = EVT_ARM;
    end else begin
      held_command_next = held_command;
      event_next        = EVT_NONE;
    end
  end

  // Advance gesture state once per sample set
  always_ff @(posedge clk) begin
    if (rst) begin
      arm_count    <= '0;
      disarm_count <= '0;
      held_command <= CMD_NONE;
    end else if (s1_advance) begin
      arm_count    <= arm_count_next;
      disarm_count <= disarm_count_next;
      held_command <= held_command_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result.lift          <= lift;
      result.pitch         <= pitch;
      result.roll          <= roll;
      result.yaw           <= yaw;
      result.command       <= held_command_next;
      result.vibrate_event <= event_next;
    end
  end

`ifndef ASSERT_OFF
  a_lift_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.lift <= LIFT_MAX)
    else $error("lift above left_y / 6 range");

  a_arm_event_cmd: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.vibrate_event == EVT_ARM |-> result.command == CMD_ARM)
    else $error("arm event without armed command");

  a_disarm_event_cmd: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.vibrate_event == EVT_DISARM
      |-> result.command == CMD_DISARM)
    else $error("disarm event without disarmed command");

  a_cmd_sticky: assert property (@(posedge clk) disable iff (rst)
    held_command != CMD_NONE |=> held_command != CMD_NONE)
    else $error("held command returned to none");

  a_counts_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(arm_count != '0 && disarm_count != '0))
    else $error("arm and disarm counters both running");
`endif

endmodule
